// ----- hw/rtl/drsc_pkg.sv -----
// ----------------------------------------------------------------------------
// drsc_pkg
// shared types, constants and exp tables for the dense classifier
// ----------------------------------------------------------------------------
package drsc_pkg;

  localparam int OUTPUTS_DEF = 10;
  localparam int INPUTS_DEF  = 784;
  localparam int IDX_W       = 13;
  localparam int VAL_W       = 16;
  localparam int ACC_W       = 32;
  localparam int PROB_W      = 17;
  localparam int CLS_W       = 4;
  localparam int EXP_W       = 17;
  localparam int EXP_INT_LEN = 12;

  localparam logic [1:0] OP_WEIGHT = 2'd0;
  localparam logic [1:0] OP_BIAS   = 2'd1;
  localparam logic [1:0] OP_PIXEL  = 2'd2;

  typedef struct packed {
    logic clear;      // zero accumulators, drop started flag
    logic pix;        // accept pixel beat into datapath
    logic max_step;   // fold one class into max
    logic exp_step;   // exp of one class, add to sum
    logic div_start;  // start divider for one class
    logic emit;       // load output register
    logic [5:0] sel;  // class under work
  } drsc_cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_busy;
    logic pix_done;
  } drsc_sts_t;

  function automatic logic [16:0] exp_int_f(input logic [3:0] i);
    case (i)
      4'd0: return 17'd65536;  4'd1: return 17'd24109; 4'd2: return 17'd8869;
      4'd3: return 17'd3263;   4'd4: return 17'd1200;  4'd5: return 17'd442;
      4'd6: return 17'd162;    4'd7: return 17'd60;    4'd8: return 17'd22;
      4'd9: return 17'd8;      4'd10: return 17'd3;    4'd11: return 17'd1;
      default: return 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] exp_frac_f(input logic [3:0] i);
    case (i)
      4'd0: return 17'd65536;  4'd1: return 17'd61565;  4'd2: return 17'd57835;
      4'd3: return 17'd54331;  4'd4: return 17'd51039;  4'd5: return 17'd47947;
      4'd6: return 17'd45042;  4'd7: return 17'd42313;  4'd8: return 17'd39750;
      4'd9: return 17'd37341;  4'd10: return 17'd35079; 4'd11: return 17'd32954;
      4'd12: return 17'd30957; 4'd13: return 17'd29081; 4'd14: return 17'd27319;
      default: return 17'd25664;
    endcase
  endfunction

endpackage

// ----- hw/rtl/dense_relu_softmax_classifier.sv -----
// ----------------------------------------------------------------------------
// dense_relu_softmax_classifier
// fully connected layer with relu, table softmax and argmax
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (low bit up)                        tuser
// in_      in   op[1:0] index[14:2] value[30:15]                  -    tlast=last
// out_     out  class_index[3:0] probability[20:4] predicted[24:21] - tlast=last_result
//
// writes and pixels are accepted only in the run state; the pixel marked last closes the image
// closing: wait, max and exp passes, then a serial divide per class, then
// OUTPUTS result beats, one per cycle unless stalled by out_tready
// reset clears control and accumulators; weight and bias stores are not cleared
// ----------------------------------------------------------------------------
module dense_relu_softmax_classifier import drsc_pkg::*; #(
  parameter int OUTPUTS = OUTPUTS_DEF,
  parameter int INPUTS  = INPUTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // op, index, value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // class_index, probability, predicted
  output logic        out_tlast
);
  drsc_cmd_t cmd;
  drsc_sts_t sts;
  logic wr_en;
  logic [CLS_W-1:0] oc, opd;
  logic [PROB_W-1:0] opb;

  drsc_ctrl #(.OUTPUTS(OUTPUTS)) u_ctrl (
    .clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .op(in_tdata[1:0]), .last(in_tlast), .wr_en, .cmd, .sts
  );

  drsc_datapath #(.OUTPUTS(OUTPUTS), .INPUTS(INPUTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .op(in_tdata[1:0]), .idx(in_tdata[14:2]),
    .val(in_tdata[30:15]), .wr_en, .out_valid(out_tvalid), .out_ready(out_tready),
    .out_cls(oc), .out_prob(opb), .out_pred(opd), .out_last(out_tlast)
  );

  assign out_tdata = {7'd0, opd, opb, oc};
endmodule

// ----- hw/rtl/drsc_div.sv -----
// ----------------------------------------------------------------------------
// drsc_div
// radix-2 restoring divider, rounded quotient (n*65536 + d/2) / d
// ----------------------------------------------------------------------------
module drsc_div import drsc_pkg::*; #(
  parameter int SUM_W = 21
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [EXP_W-1:0]   num,
  input  logic [SUM_W-1:0]   den,
  output logic               done,
  output logic [PROB_W-1:0]  quo
);
  localparam int N_W  = EXP_W + 16 + 1;
  localparam int CW   = $clog2(N_W + 1);

  logic [N_W-1:0]   n_r, n_nxt;
  logic [SUM_W:0]   rem_r, rem_nxt;
  logic [N_W-1:0]   q_r, q_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [SUM_W+1:0] trial;

  always_comb begin
    n_nxt = n_r; rem_nxt = rem_r; q_nxt = q_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, n_r[N_W-1]} - {1'b0, {1'b0, den}};
    if (start) begin
      n_nxt = {1'b0, num, 16'd0} + N_W'(den >> 1);
      rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(N_W); busy_nxt = 1'b1;
    end else if (busy_r) begin
      n_nxt = n_r << 1;
      if (!trial[SUM_W+1]) begin
        rem_nxt = trial[SUM_W:0];
        q_nxt = {q_r[N_W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[SUM_W-1:0], n_r[N_W-1]};
        q_nxt = {q_r[N_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    n_r <= n_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
  end

  assign done = done_r;
  assign quo  = q_r[PROB_W-1:0];
endmodule

// ----- hw/rtl/drsc_datapath.sv -----
// ----------------------------------------------------------------------------
// drsc_datapath
// stores, accumulators, relu max, exp, sum, divider and output register
// ----------------------------------------------------------------------------
module drsc_datapath import drsc_pkg::*; #(
  parameter int OUTPUTS = OUTPUTS_DEF,
  parameter int INPUTS  = INPUTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  drsc_cmd_t         cmd,
  output drsc_sts_t         sts,
  input  logic [1:0]        op,
  input  logic [IDX_W-1:0]  idx,
  input  logic [VAL_W-1:0]  val,
  input  logic              wr_en,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CLS_W-1:0]  out_cls,
  output logic [PROB_W-1:0] out_prob,
  output logic [CLS_W-1:0]  out_pred,
  output logic              out_last
);
  localparam int OW    = (OUTPUTS > 1) ? $clog2(OUTPUTS) : 1;
  localparam int KW    = (INPUTS > 1) ? $clog2(INPUTS) : 1;
  localparam int SUM_W = EXP_W + OW;
  localparam int WIDX_W = $clog2(OUTPUTS * INPUTS);
  localparam logic signed [ACC_W:0] SMAX = (ACC_W+1)'(33'sd2147483647);
  localparam logic signed [ACC_W:0] SMIN = -(ACC_W+1)'(33'sd2147483648);

  // one weight memory per class, read together per pixel
  logic [VAL_W-1:0] wmem [OUTPUTS][INPUTS];
  logic [VAL_W-1:0] bias_r [OUTPUTS];
  logic [VAL_W-1:0] wrd_r  [OUTPUTS];
  logic signed [ACC_W-1:0] acc_r [OUTPUTS];
  logic [7:0]  px_r;
  logic        pv_r, pin_r, start_r;
  logic [ACC_W-1:0] rmax_r;
  logic [EXP_W-1:0] e_r [OUTPUTS];
  logic [SUM_W-1:0] sum_r;
  logic [PROB_W-1:0] best_r;
  logic [CLS_W-1:0]  pred_r;
  logic [PROB_W-1:0] prob_r [OUTPUTS];
  logic        ov_r;
  logic [CLS_W-1:0] oc_r, op_r;
  logic [PROB_W-1:0] opb_r;
  logic        ol_r;
  logic        div_done;
  logic [PROB_W-1:0] quo;

  logic [OW-1:0] sel;
  logic [WIDX_W:0] w_o, w_k;
  logic [ACC_W-1:0] rsel, dsel;
  logic [ACC_W:0]   ish;
  logic [15:0]      ival;
  logic [33:0]      eprod;

  assign sel = cmd.sel[OW-1:0];

  // split weight address into class and pixel by compares against class bases
  always_comb begin
    w_o = '0;
    w_k = (WIDX_W+1)'(idx);
    for (int o = 1; o < OUTPUTS; o++) begin
      if (32'(idx) >= o * INPUTS) begin
        w_o = (WIDX_W+1)'(o);
        w_k = (WIDX_W+1)'(32'(idx) - o * INPUTS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && op == OP_WEIGHT && 32'(idx) < OUTPUTS * INPUTS)
      wmem[w_o[OW-1:0]][w_k[KW-1:0]] <= val;
    if (wr_en && op == OP_BIAS && 32'(idx) < OUTPUTS)
      bias_r[idx[OW-1:0]] <= val;
  end

  for (genvar o = 0; o < OUTPUTS; o++) begin : g_rd
    always_ff @(posedge clk) wrd_r[o] <= wmem[o][idx[KW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0; start_r <= 1'b0;
    end else begin
      pv_r <= cmd.pix;
      if (cmd.clear) start_r <= 1'b0;
      else if (pv_r) start_r <= 1'b1;
    end
    if (cmd.pix) begin
      px_r  <= val[7:0];
      pin_r <= 32'(idx) < INPUTS;
    end
  end

  for (genvar o = 0; o < OUTPUTS; o++) begin : g_acc
    logic signed [ACC_W-1:0] base;
    logic signed [VAL_W+8:0] prod;
    logic signed [ACC_W:0]   s;
    always_comb begin
      base = start_r ? acc_r[o] : ACC_W'($signed(bias_r[o])) <<< 8;
      prod = (VAL_W+9)'($signed(wrd_r[o])) * (VAL_W+9)'($signed({1'b0, px_r}));
      s = (ACC_W+1)'(base) + (pin_r ? (ACC_W+1)'(prod) : '0);
    end
    always_ff @(posedge clk) begin
      if (!rst_n || cmd.clear) acc_r[o] <= '0;
      else if (pv_r) acc_r[o] <= (s > SMAX) ? SMAX[ACC_W-1:0] :
                                 (s < SMIN) ? SMIN[ACC_W-1:0] : s[ACC_W-1:0];
    end
  end

  assign sts.pix_done = !pv_r;

  always_comb begin
    rsel = acc_r[sel][ACC_W-1] ? '0 : acc_r[sel];
    dsel = rmax_r - rsel;
    ish  = ((ACC_W+1)'(dsel) + (ACC_W+1)'(32768)) >> 16;
    ival = ish[15:0];
    eprod = 34'(exp_int_f(ival[7:4])) * 34'(exp_frac_f(ival[3:0])) + 34'd32768;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      rmax_r <= '0; sum_r <= '0;
    end
    if (cmd.max_step && rsel > rmax_r) rmax_r <= rsel;
    if (cmd.exp_step) begin
      if (ish[ACC_W:8] != '0 || ival[7:4] >= 4'(EXP_INT_LEN)) begin
        e_r[sel] <= '0;
      end else begin
        e_r[sel] <= eprod[16+EXP_W-1:16];
        sum_r <= sum_r + SUM_W'(eprod[16+EXP_W-1:16]);
      end
    end
    if (div_done) begin
      prob_r[sel] <= quo;
      if (sel == '0 || quo > best_r) begin
        best_r <= quo; pred_r <= CLS_W'(sel);
      end
    end
  end

  drsc_div #(.SUM_W(SUM_W)) u_div (
    .clk, .rst_n, .start(cmd.div_start), .num(e_r[sel]), .den(sum_r),
    .done(div_done), .quo
  );
  assign sts.div_done = div_done;

  always_ff @(posedge clk) begin
    if (!rst_n) ov_r <= 1'b0;
    else if (cmd.emit) ov_r <= 1'b1;
    else if (out_ready) ov_r <= 1'b0;
    if (cmd.emit) begin
      oc_r <= CLS_W'(sel); opb_r <= prob_r[sel]; op_r <= pred_r;
      ol_r <= (32'(sel) == OUTPUTS - 1);
    end
  end
  assign sts.out_busy = ov_r && !out_ready;
  assign out_valid = ov_r;
  assign out_cls = oc_r; assign out_prob = opb_r;
  assign out_pred = op_r; assign out_last = ol_r;
endmodule

// ----- hw/rtl/drsc_ctrl.sv -----
// ----------------------------------------------------------------------------
// drsc_ctrl
// sequencer: accumulate, max, exp, divide, emit
// ----------------------------------------------------------------------------
module drsc_ctrl import drsc_pkg::*; #(
  parameter int OUTPUTS = OUTPUTS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] op,
  input  logic       last,
  output logic       wr_en,
  output drsc_cmd_t  cmd,
  input  drsc_sts_t  sts
);
  typedef enum logic [6:0] {
    S_RUN  = 7'b0000001, S_WAIT = 7'b0000010, S_MAX = 7'b0000100,
    S_EXP  = 7'b0001000, S_DIV  = 7'b0010000, S_DWT = 7'b0100000,
    S_EMIT = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic acc;

  assign in_ready = (state_r == S_RUN);
  assign acc = in_valid && in_ready;
  assign wr_en = acc && (op == OP_WEIGHT || op == OP_BIAS);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r;
    cmd = '0; cmd.sel = cnt_r;
    unique case (state_r)
      S_RUN: begin
        cmd.pix = acc && op == OP_PIXEL;
        if (cmd.pix && last) begin
          state_nxt = S_WAIT; cnt_nxt = '0;
        end
      end
      S_WAIT: if (sts.pix_done) state_nxt = S_MAX;
      S_MAX: begin
        cmd.max_step = 1'b1; cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == OUTPUTS - 1) begin
          state_nxt = S_EXP; cnt_nxt = '0;
        end
      end
      S_EXP: begin
        cmd.exp_step = 1'b1; cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == OUTPUTS - 1) begin
          state_nxt = S_DIV; cnt_nxt = '0;
        end
      end
      S_DIV: begin
        cmd.div_start = 1'b1; state_nxt = S_DWT;
      end
      S_DWT: if (sts.div_done) begin
        cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == OUTPUTS - 1) begin
          state_nxt = S_EMIT; cnt_nxt = '0;
        end else state_nxt = S_DIV;
      end
      S_EMIT: if (!sts.out_busy) begin
        cmd.emit = 1'b1; cnt_nxt = cnt_r + 1'b1;
        if (32'(cnt_r) == OUTPUTS - 1) begin
          cmd.clear = 1'b1; state_nxt = S_RUN; cnt_nxt = '0;
        end
      end
      default: state_nxt = S_RUN;
    endcase
    if (state_r == S_WAIT) begin
      cmd.clear = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN; cnt_r <= '0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt;
    end
  end

  a_ready_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_RUN) else $error("ready outside run");
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> !sts.out_busy) else $error("emit over busy output");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) < OUTPUTS) else $error("count out of range");
endmodule

// ----- tb/dense_relu_softmax_classifier_tb.sv -----
// ----------------------------------------------------------------------------
// dense_relu_softmax_classifier_tb
// drives weight, bias, pixel and unused-op beats into the classifier and checks every
// result beat against a fixed point predictor of the layer, relu, softmax and argmax
// ----------------------------------------------------------------------------
module dense_relu_softmax_classifier_tb;
  import drsc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NCLS     = OUTPUTS_DEF;
  localparam int NPIX     = INPUTS_DEF;
  localparam int LIMIT    = 2000000;
  localparam int CLOSE_WAIT = 450;

  typedef struct packed {
    logic [CLS_W-1:0]  cls;
    logic [PROB_W-1:0] prob;
    logic [CLS_W-1:0]  pred;
    logic              lst;
  } class_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic        out_tlast;

  logic signed [VAL_W-1:0] weights [NCLS*NPIX];
  logic signed [VAL_W-1:0] biases [NCLS];
  int                      acc [NCLS];
  bit                      started;
  class_result_t           scores_q[$];
  int                      errors;
  int                      cycles;
  bit                      hold_req;
  bit                      no_idle;
  int                      used_pos [4] = '{0, 1, 2, NPIX-1};
  int                      exp_whole [EXP_INT_LEN] = '{65536, 24109, 8869, 3263, 1200, 442,
                                                       162, 60, 22, 8, 3, 1};
  int                      exp_part [16] = '{65536, 61565, 57835, 54331, 51039, 47947,
                                            45042, 42313, 39750, 37341, 35079, 32954,
                                            30957, 29081, 27319, 25664};

  dense_relu_softmax_classifier u_top (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    errors++;
  endtask

  function automatic void predict_layer(input logic [1:0] op, input logic [IDX_W-1:0] idx,
                                        input logic [VAL_W-1:0] val, input logic last);
    longint s;
    int unsigned r [NCLS];
    int unsigned e [NCLS];
    int unsigned rmax, tot, best, pred, d, i;
    class_result_t res;
    if (op == OP_WEIGHT) begin
      if (idx < NCLS*NPIX) weights[idx] = val;
      return;
    end
    if (op == OP_BIAS) begin
      if (idx < NCLS) biases[idx] = val;
      return;
    end
    if (op != OP_PIXEL) return;
    if (!started) begin
      for (int o = 0; o < NCLS; o++) acc[o] = int'(biases[o]) * 256;
      started = 1;
    end
    if (idx < NPIX) begin
      for (int o = 0; o < NCLS; o++) begin
        s = longint'(acc[o]) + longint'(weights[o*NPIX+idx]) * longint'(val[7:0]);
        if (s > 64'sh7fffffff) s = 64'sh7fffffff;
        if (s < -64'sh80000000) s = -64'sh80000000;
        acc[o] = int'(s);
      end
    end
    if (!last) return;
    rmax = 0;
    tot = 0;
    for (int o = 0; o < NCLS; o++) begin
      r[o] = acc[o] > 0 ? acc[o] : 0;
      if (r[o] > rmax) rmax = r[o];
    end
    for (int o = 0; o < NCLS; o++) begin
      d = rmax - r[o];
      i = 32'((longint'(d) + 32768) >> 16);
      if ((i >> 4) >= EXP_INT_LEN) e[o] = 0;
      else e[o] = 32'((longint'(exp_whole[i>>4]) * exp_part[i & 15] + 32768) >> 16);
      tot += e[o];
    end
    best = 0;
    pred = 0;
    for (int o = 0; o < NCLS; o++) begin
      e[o] = 32'((longint'(e[o]) * 65536 + tot / 2) / tot);
      if (o == 0 || e[o] > best) begin
        best = e[o];
        pred = o;
      end
    end
    for (int o = 0; o < NCLS; o++) begin
      res.cls = CLS_W'(o);
      res.prob = PROB_W'(e[o]);
      res.pred = CLS_W'(pred);
      res.lst = (o == NCLS-1);
      scores_q.push_back(res);
    end
    for (int o = 0; o < NCLS; o++) acc[o] = 0;
    started = 0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(15, 60);
  endfunction

  task automatic send_beat(input int op, input int idx, input int val, input int last);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, VAL_W'(val), IDX_W'(idx), 2'(op)};
    in_tlast  <= 1'(last);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_layer(2'(op), IDX_W'(idx), VAL_W'(val), 1'(last));
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (scores_q.size() != 0) @(posedge clk);
    repeat (CLOSE_WAIT) @(posedge clk);
  endtask

  task automatic send_image(input int npix);
    int p;
    for (int k = 0; k < npix; k++) begin
      if ($urandom_range(0, 9) == 0) p = $urandom_range(NPIX, 8191);
      else p = used_pos[$urandom_range(0, 3)];
      send_beat(OP_PIXEL, p, $urandom, k == npix-1);
    end
  endtask

  task automatic test_load_stores();
    for (int o = 0; o < NCLS; o++) send_beat(OP_BIAS, o, $urandom_range(0, 4095) - 2048, 0);
    for (int o = 0; o < NCLS; o++)
      for (int k = 0; k < 4; k++)
        send_beat(OP_WEIGHT, o*NPIX + used_pos[k], $urandom, 0);
    send_beat(OP_WEIGHT, 0, 16'h7fff, 1'b1);
    send_beat(OP_WEIGHT, NPIX, 16'h8000, 0);
    send_beat(OP_BIAS, 0, 16'h7fff, 0);
    send_beat(OP_BIAS, NCLS-1, 16'h8000, 1'b1);
  endtask

  task automatic test_special_cases();
    send_beat(OP_PIXEL, 0, 16'hff00, 0);
    send_beat(OP_PIXEL, NPIX-1, 16'h00ff, 0);
    send_beat(OP_WEIGHT, 2*NPIX+1, 16'h1234, 0);
    send_beat(OP_PIXEL, 1, 16'hffff, 1'b1);
    send_beat(OP_WEIGHT, NCLS*NPIX, 16'h5555, 0);
    send_beat(OP_WEIGHT, 13'h1fff, 16'haaaa, 0);
    send_beat(OP_BIAS, NCLS, 16'h1111, 0);
    send_beat(OP_BIAS, 13'h1fff, 16'h2222, 1'b1);
    send_beat(2'd3, 13'h1fff, 16'hffff, 1'b1);
    send_beat(OP_PIXEL, 13'h1fff, 16'hffff, 1'b1);
    send_beat(OP_PIXEL, NPIX, 16'h0000, 0);
    send_beat(OP_PIXEL, 2, 16'h0080, 1'b1);
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_req = 1;
    send_image(3);
    send_image(2);
    send_image(4);
    wait_drained();
  endtask

  task automatic test_random(input int nitems);
    int sent;
    int n, r, o;
    sent = 0;
    while (sent < nitems) begin
      no_idle = ($urandom_range(0, 5) == 0);
      r = $urandom_range(0, 99);
      if (r < 65) begin
        n = $urandom_range(1, 6);
        send_image(n);
        sent += n;
      end else if (r < 80) begin
        o = $urandom_range(0, NCLS-1);
        send_beat(OP_WEIGHT, o*NPIX + used_pos[$urandom_range(0, 3)], $urandom, $urandom);
        sent++;
      end else if (r < 88) begin
        send_beat(OP_BIAS, $urandom_range(0, NCLS-1), $urandom, $urandom);
        sent++;
      end else if (r < 95) begin
        send_beat($urandom_range(0, 1), $urandom_range(0, 8191), $urandom, $urandom);
        sent++;
      end else begin
        send_beat(2'd3, $urandom, $urandom, $urandom);
      end
      if ($urandom_range(0, 19) == 0) wait_drained();
    end
    no_idle = 0;
  endtask

  always @(posedge clk) begin
    class_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (scores_q.size() == 0) begin
        report($sformatf("unexpected result beat %h", out_tdata));
      end else begin
        want = scores_q.pop_front();
        if (out_tdata[3:0] != want.cls)
          report($sformatf("class_index %0d, want %0d", out_tdata[3:0], want.cls));
        if (out_tdata[20:4] != want.prob)
          report($sformatf("class %0d probability %0d, want %0d", want.cls,
                           out_tdata[20:4], want.prob));
        if (out_tdata[24:21] != want.pred)
          report($sformatf("class %0d predicted %0d, want %0d", want.cls,
                           out_tdata[24:21], want.pred));
        if (out_tlast != want.lst)
          report($sformatf("class %0d last %0b, want %0b", want.cls, out_tlast, want.lst));
      end
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (700) @(posedge clk);
        hold_req = 0;
        out_tready <= 1'b1;
      end else if (!no_idle && $urandom_range(0, 40) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(20, 80)) @(posedge clk);
        out_tready <= 1'b1;
      end else begin
        out_tready <= no_idle || ($urandom_range(0, 3) != 0);
      end
    end
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    errors = 0;
    hold_req = 0;
    no_idle = 0;
    started = 0;
    for (int o = 0; o < NCLS; o++) begin
      acc[o] = 0;
      biases[o] = '0;
    end
    for (int k = 0; k < NCLS*NPIX; k++) weights[k] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_stores();
    test_special_cases();
    test_backpressure();
    test_random(135);
    wait_drained();
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
